>>> rtl/assert_macros.svh
// Assertion macros for the checker file of the hash core.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/sha2_pkg.sv
// Types, constants and round functions for the SHA-256/SHA-224 hash core.
// No dependencies; used by every module of the core.
package sha2_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned WinLen  = 16;

  // Mode codes
  localparam logic MODE_SHA256 = 1'b0;
  localparam logic MODE_SHA224 = 1'b1;

  // Index of the last digest word per mode
  localparam logic [2:0] LAST_IDX_SHA256 = 3'd7;
  localparam logic [2:0] LAST_IDX_SHA224 = 3'd6;

  typedef logic [7:0][WordW-1:0] state_t;

  typedef struct packed {
    logic [WordW-1:0] message_word;
    logic             final_block;
  } msg_word_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic             digest_last;
  } digest_word_t;

  typedef struct packed {
    logic shift_in;
    logic expand;
  } sched_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } round_ctrl_t;

  localparam logic [WordW-1:0] IV256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] IV224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam logic [WordW-1:0] K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic state_t init_value(input logic mode);
    state_t s;
    for (int i = 0; i < 8; i++) begin
      s[i] = (mode == MODE_SHA224) ? IV224[i] : IV256[i];
    end
    return s;
  endfunction

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

>>> rtl/sha2_sched.sv
// Message schedule: a sixteen-word shifting window, filled by input words
// and extended in place during the rounds. Depends on sha2_pkg.
module sha2_sched (
  input  logic                          clk_i,
  input  sha2_pkg::sched_ctrl_t         ctrl_i,
  input  logic [sha2_pkg::WordW-1:0]    word_i,
  output logic [sha2_pkg::WordW-1:0]    w_o
);

  logic [sha2_pkg::WinLen-1:0][sha2_pkg::WordW-1:0] win_q;
  logic [sha2_pkg::WordW-1:0] w_new;

  // Next schedule word from the window (window slot k holds w[t+k])
  assign w_new = sha2_pkg::small_sigma1(win_q[14]) + win_q[9]
               + sha2_pkg::small_sigma0(win_q[1]) + win_q[0];

  assign w_o = win_q[0];

  // Shift the window: new message word or expanded word enters at the top
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_in || ctrl_i.expand) begin
      for (int i = 0; i < sha2_pkg::WinLen - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[sha2_pkg::WinLen-1] <= ctrl_i.shift_in ? word_i : w_new;
    end
  end

endmodule

>>> rtl/sha2_round.sv
// Round unit: the eight working variables and one compression round per
// step, shared across all 64 rounds. Depends on sha2_pkg.
module sha2_round (
  input  logic                          clk_i,
  input  sha2_pkg::round_ctrl_t         ctrl_i,
  input  sha2_pkg::state_t              init_i,
  input  logic [sha2_pkg::WordW-1:0]    k_i,
  input  logic [sha2_pkg::WordW-1:0]    w_i,
  output sha2_pkg::state_t              vars_o
);

  sha2_pkg::state_t v_q;
  sha2_pkg::state_t v_next;
  logic [sha2_pkg::WordW-1:0] t1, t2, ch, maj;

  // One round of the compression function
  always_comb begin
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + sha2_pkg::big_sigma1(v_q[4]) + ch + k_i + w_i;
    t2  = sha2_pkg::big_sigma0(v_q[0]) + maj;
    v_next[0] = t1 + t2;
    v_next[1] = v_q[0];
    v_next[2] = v_q[1];
    v_next[3] = v_q[2];
    v_next[4] = v_q[3] + t1;
    v_next[5] = v_q[4];
    v_next[6] = v_q[5];
    v_next[7] = v_q[6];
  end

  // Load from the chaining value, or advance one round
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v_q <= init_i;
    end else if (ctrl_i.step) begin
      v_q <= v_next;
    end
  end

  assign vars_o = v_q;

endmodule

>>> rtl/sha256_sha224_hash_core.sv
// Top level of the SHA-256/SHA-224 hash core: sequencer, chaining value and
// digest output. Depends on sha2_pkg, sha2_sched and sha2_round.
//
//   channel  direction  payload         handshake
//   in       input      msg_word_t      in_valid_i / in_ready_o
//   out      output     digest_word_t   out_valid_o / out_ready_i
//   cfg      input      1-bit mode      cfg_valid_i / cfg_ready_o
//
// Words 1 to 15 of a block only fill the schedule window. The sixteenth word
// starts the 64 rounds on the shared round unit, then the chaining add. A
// final block then shows 8 (SHA-256) or 7 (SHA-224) digest words, one per
// cycle while out_ready_i is high. Reset selects SHA-256 and loads its
// initial value; input and mode writes are refused while rounds run or the
// digest is being drained.
module sha256_sha224_hash_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sha2_pkg::msg_word_t    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sha2_pkg::digest_word_t out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [5:0]        rnd_q, rnd_d;
  logic [3:0]        wpos_q, wpos_d;
  logic [2:0]        idx_q, idx_d;
  logic              final_q, final_d;
  logic              mode_q, mode_d;
  sha2_pkg::state_t  h_q, h_d;

  sha2_pkg::sched_ctrl_t      sched_ctrl;
  sha2_pkg::round_ctrl_t      round_ctrl;
  sha2_pkg::state_t           vars;
  logic [sha2_pkg::WordW-1:0] w_cur;
  logic                       in_acc, cfg_acc, out_acc, is_last;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_acc     = out_valid_o && out_ready_i;

  assign is_last = (idx_q == ((mode_q == sha2_pkg::MODE_SHA224) ?
                    sha2_pkg::LAST_IDX_SHA224 : sha2_pkg::LAST_IDX_SHA256));

  assign out_data_o.digest_word = h_q[idx_q];
  assign out_data_o.digest_last = is_last;

  // Drive the schedule window and the round unit
  assign sched_ctrl.shift_in = in_acc;
  assign sched_ctrl.expand   = (state_q == S_ROUND);
  assign round_ctrl.load     = in_acc && (wpos_q == 4'hf);
  assign round_ctrl.step     = (state_q == S_ROUND);

  sha2_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .word_i (in_data_i.message_word),
    .w_o    (w_cur)
  );

  sha2_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (round_ctrl),
    .init_i (h_q),
    .k_i    (sha2_pkg::K[rnd_q]),
    .w_i    (w_cur),
    .vars_o (vars)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    wpos_d  = wpos_q;
    idx_d   = idx_q;
    final_d = final_q;
    mode_d  = mode_q;
    h_d     = h_q;
    unique case (state_q)
      S_IDLE: begin
        if (cfg_acc) begin
          mode_d = cfg_data_i;
          h_d    = sha2_pkg::init_value(cfg_data_i);
          wpos_d = '0;
        end else if (in_acc) begin
          wpos_d = wpos_q + 4'd1;
          if (wpos_q == 4'hf) begin
            final_d = in_data_i.final_block;
            rnd_d   = '0;
            state_d = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(sha2_pkg::Rounds - 1)) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + vars[i];
        end
        idx_d   = '0;
        state_d = final_q ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (out_acc) begin
          if (is_last) begin
            h_d     = sha2_pkg::init_value(mode_q);
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, counters, mode and chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rnd_q   <= '0;
      wpos_q  <= '0;
      idx_q   <= '0;
      final_q <= 1'b0;
      mode_q  <= sha2_pkg::MODE_SHA256;
      h_q     <= sha2_pkg::init_value(sha2_pkg::MODE_SHA256);
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      wpos_q  <= wpos_d;
      idx_q   <= idx_d;
      final_q <= final_d;
      mode_q  <= mode_d;
      h_q     <= h_d;
    end
  end

endmodule

>>> rtl/sha2_checker.sv
// Port-level checker for the hash core, bound to the top level below.
// Depends on sha2_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sha2_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input sha2_pkg::digest_word_t out_data_o,
  input logic                   cfg_ready_o
);

  // No input word is taken while digest words are pending
  `ASSERT_IMP(a_busy_while_out, out_valid_o, !in_ready_o)

  // Input readiness implies the mode register can be written too
  `ASSERT_IMP(a_in_implies_cfg, in_ready_o, cfg_ready_o)

  // Drop the output after the final digest word is taken
  `ASSERT_NXT(a_last_ends, out_valid_o && out_ready_i && out_data_o.digest_last, !out_valid_o)

  // Hold a stalled digest word
  `ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

endmodule

bind sha256_sha224_hash_core sha2_checker u_sha2_checker (.*);

>>> tb/sv/sha_digest_sb_pkg.sv
// Scoreboard for the SHA-256/SHA-224 hash core bench: its own constant tables,
// a bit-exact digest predictor and the queue of digest words still owed.
// Depends on sha2_pkg for the payload structs and the mode codes only.
package sha_digest_sb_pkg;

  localparam logic [31:0] START256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] START224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam logic [31:0] ADD_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Rotate right: take a 32-bit window out of the word doubled up
  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  class digest_scoreboard;
    logic        mode;
    logic [31:0] chain [8];
    logic [31:0] sched [16];
    int unsigned pos;
    sha2_pkg::digest_word_t expected_digest [$];
    int unsigned mismatches;
    int unsigned digests_seen;
    int unsigned blocks_done;
    int unsigned messages_done;

    function new();
      mismatches    = 0;
      digests_seen  = 0;
      blocks_done   = 0;
      messages_done = 0;
      set_mode(sha2_pkg::MODE_SHA256);
    endfunction

    // Reload the chaining value of the mode and restart the block
    function void set_mode(input logic m);
      mode = m;
      for (int i = 0; i < 8; i++) begin
        chain[i] = (m == sha2_pkg::MODE_SHA224) ? START224[i] : START256[i];
      end
      pos = 0;
    endfunction

    function int unsigned pending();
      return expected_digest.size();
    endfunction

    // Run the 64 rounds over the stored block, expanding in place
    function void compress();
      logic [31:0] v [8];
      logic [31:0] w, t1, t2, s0, s1, x2, x15;
      for (int i = 0; i < 8; i++) begin
        v[i] = chain[i];
      end
      for (int r = 0; r < 64; r++) begin
        if (r < 16) begin
          w = sched[r];
        end else begin
          x2  = sched[(r - 2) % 16];
          x15 = sched[(r - 15) % 16];
          s1  = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
          s0  = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
          w   = s1 + sched[(r - 7) % 16] + s0 + sched[r % 16];
          sched[r % 16] = w;
        end
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ADD_CONST[r] + w;
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        for (int i = 7; i > 0; i--) begin
          v[i] = v[i-1];
        end
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) begin
        chain[i] = chain[i] + v[i];
      end
    endfunction

    // Absorb one accepted word; queue the digest when a final block closes
    function void note_word(input sha2_pkg::msg_word_t item);
      int unsigned count;
      sha2_pkg::digest_word_t d;
      sched[pos] = item.message_word;
      if (pos != 15) begin
        pos++;
        return;
      end
      pos = 0;
      compress();
      blocks_done++;
      if (item.final_block) begin
        count = (mode == sha2_pkg::MODE_SHA224) ? 7 : 8;
        for (int unsigned k = 0; k < count; k++) begin
          d.digest_word = chain[k];
          d.digest_last = (k + 1 == count);
          expected_digest.push_back(d);
        end
        messages_done++;
        set_mode(mode);
      end
    endfunction

    // Count every mismatch, print only the first few dozen
    task report(input string what);
      mismatches++;
      if (mismatches <= 40) begin
        $display("mismatch: %s", what);
      end
    endtask

    // Compare an accepted digest word with the oldest one owed
    task check_digest(input sha2_pkg::digest_word_t got);
      sha2_pkg::digest_word_t want;
      digests_seen++;
      if (expected_digest.size() == 0) begin
        report($sformatf("digest word %0d (%h) arrived unasked", digests_seen,
                         got.digest_word));
        return;
      end
      want = expected_digest.pop_front();
      if (got.digest_word !== want.digest_word) begin
        report($sformatf("digest word %0d is %h, wanted %h", digests_seen,
                         got.digest_word, want.digest_word));
      end
      if (got.digest_last !== want.digest_last) begin
        report($sformatf("digest word %0d last flag is %b, wanted %b", digests_seen,
                         got.digest_last, want.digest_last));
      end
    endtask
  endclass

endpackage

>>> tb/sv/tb_sha256_sha224_hash_core.sv
// Top of the hash core bench: clock, reset, word and mode drivers, digest sink.
// Depends on sha2_pkg, sha_digest_sb_pkg and the sha256_sha224_hash_core RTL.
module tb_sha256_sha224_hash_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORD_TARGET   = 350;
  localparam int unsigned DIGEST_TARGET = 48;
  // Idle wait that covers a block's run inside the core, with a margin
  localparam int unsigned BLOCK_SETTLE  = 120;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  sha2_pkg::msg_word_t    in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  sha2_pkg::digest_word_t out_data_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_data_i  = 1'b0;

  bit          tx_idle     = 1'b1;
  bit          rx_idle     = 1'b1;
  int unsigned words_sent  = 0;
  int unsigned mode_writes = 0;
  int unsigned abandoned   = 0;
  int unsigned cycles      = 0;

  sha_digest_sb_pkg::digest_scoreboard sb = new();

  sha256_sha224_hash_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Count cycles and give up on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check every digest word taken from the core
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_digest(out_data_o);
    end
  end

  // Sink: stall a random number of cycles before each digest word
  initial begin : digest_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_idle ? $urandom_range(0, 6) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word after a random gap and hold it until it is taken
  task automatic send_word(input logic [31:0] w, input logic fin);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{message_word: w, final_block: fin};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(in_data_i);
    words_sent++;
  endtask

  // Drop valid before any pause that lets time pass
  task automatic hold_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write the mode only once the core has gone quiet
  task automatic write_mode(input logic m);
    hold_input();
    drain();
    repeat (BLOCK_SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_mode(m);
    mode_writes++;
  endtask

  // Whole message: flags on inner words are noise, the closing flag counts
  task automatic send_message(input int unsigned nblocks);
    logic fin;
    for (int unsigned b = 0; b < nblocks; b++) begin
      for (int i = 0; i < 16; i++) begin
        fin = (i == 15) ? (b + 1 == nblocks) : 1'($urandom_range(0, 1));
        send_word(pick_word(), fin);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned nblocks;
    int unsigned partial;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mode(sha2_pkg::MODE_SHA256);

    // Padded "abc" as one final block, inner flags toggling
    for (int i = 0; i < 16; i++) begin
      send_word((i == 0) ? 32'h61626380 : (i == 15) ? 32'h00000018 : 32'h0,
                (i == 15) ? 1'b1 : 1'(i % 2));
    end
    // Abandon a partly filled block of all-ones words with a mode change
    for (int i = 0; i < 5; i++) begin
      send_word('1, 1'b1);
    end
    abandoned++;
    write_mode(sha2_pkg::MODE_SHA224);

    // Random messages, mode changes and broken blocks
    while (words_sent < WORD_TARGET || sb.digests_seen < DIGEST_TARGET) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (sb.messages_done == 3 || $urandom_range(0, 7) == 0) begin
        hold_input();
        drain();
      end
      case ($urandom_range(0, 9))
        0: write_mode(1'($urandom_range(0, 1)));
        1: begin
          partial = $urandom_range(1, 15);
          for (int unsigned i = 0; i < partial; i++) begin
            send_word(pick_word(), 1'($urandom_range(0, 1)));
          end
          abandoned++;
          write_mode(1'($urandom_range(0, 1)));
        end
        default: begin
          nblocks = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
          send_message(nblocks);
        end
      endcase
    end

    // Wind down: let every owed digest out, then watch for strays
    hold_input();
    drain();
    repeat (BLOCK_SETTLE) @(posedge clk_i);
    $display("sent %0d words in %0d blocks, %0d messages, %0d digest words checked",
             words_sent, sb.blocks_done, sb.messages_done, sb.digests_seen);
    $display("%0d mode writes, %0d messages dropped part way, %0d mismatches",
             mode_writes, abandoned, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
